// ===== sv/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: shared types, constants and helpers of the sleep stage classifier
// Fixed-point constants, register indexes, status and stage codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int NUM_STAGES = 5;
  localparam int STAGE_W    = 3;

  // configuration register indexes
  localparam logic [2:0] REG_POP_PRESENT  = 3'd0;
  localparam logic [2:0] REG_SPINDLE_THR  = 3'd1;
  localparam logic [2:0] REG_SLOW_THR     = 3'd2;
  localparam logic [2:0] REG_VAR_THR      = 3'd3;
  localparam logic [2:0] REG_INTERVAL     = 3'd4;

  // result status codes
  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_TOO_SOON = 2'd1;
  localparam logic [1:0] ST_NO_POP   = 2'd2;

  // stage codes
  localparam logic [STAGE_W-1:0] STG_WAKE  = 3'd0;
  localparam logic [STAGE_W-1:0] STG_NREM1 = 3'd1;
  localparam logic [STAGE_W-1:0] STG_NREM2 = 3'd2;
  localparam logic [STAGE_W-1:0] STG_NREM3 = 3'd3;
  localparam logic [STAGE_W-1:0] STG_REM   = 3'd4;

  // fixed-point constants
  localparam logic [15:0] ONE_Q15    = 16'd32768;
  localparam logic [15:0] HALF_Q15   = 16'd16384;
  localparam logic [14:0] DECAY_Q15  = 15'd31130;  // 0.95
  localparam logic [15:0] STEP_Q15   = 16'd328;    // 0.01
  localparam logic [23:0] RATE_LO    = 24'd2560;   // 10 Hz
  localparam logic [23:0] RATE_HI    = 24'd12800;  // 50 Hz
  localparam logic [23:0] RATE_NREM1 = 24'd5120;   // 20 Hz

  // reset values of the configuration
  localparam logic [15:0] SPINDLE_THR_RST = 16'd19661;
  localparam logic [15:0] SLOW_THR_RST    = 16'd22938;
  localparam logic [15:0] VAR_THR_RST     = 16'd13107;
  localparam logic [23:0] INTERVAL_RST    = 24'd25600;

  // per-item detection flags, worked out from the registered item
  typedef struct packed {
    logic spindle;
    logic slow_wave;
    logic rem;
    logic low_rate;
  } det_t;

  function automatic logic [15:0] rem_decay(input logic [15:0] x);
    logic [30:0] prod;
    prod = x * DECAY_Q15;
    return prod[30:15];
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [23:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [23:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[40] ? '1 : s[39:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/sleep_stage_classifier.sv =====
// ----------------------------------------------------------------------------
// sleep_stage_classifier: streaming sleep stage classifier
// Detects spindles, slow waves and REM, classifies the stage, keeps stats.
// ----------------------------------------------------------------------------
// The block takes one update transaction per clock while the output is
// not stalled and returns one result transaction for each. The accepted
// item lands in the input register, then the result register loads from it
// and presents the result transaction. Threshold compares (including the
// synchrony square), the stage decision, counters and time accumulators are
// all worked out combinationally from the input register. The only loop
// that bounds the rate is the state update, so the sustained rate is one
// item per cycle while the output is not stalled. A stalled result holds in
// the output register while one more item waits in the input register.
// Skipped updates (too soon, no population) report the state unchanged.
// Configuration must only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_stage_classifier
  import ssc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // config write port
  input  wire logic         cfg_write,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata, low bit up: synchrony[15:0], population_rate[39:16],
  // elapsed_ms[63:40]
  input  wire logic [63:0]  s_tdata,
  // output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata, low bit up: stage[2:0], spindle_hit[3], slow_hit[4],
  // rem_level[20:5], spindle_total[52:21], slow_wave_total[84:53],
  // stage_time[116:85], stage_sum_time[156:117], consolidation[172:157],
  // run_time[212:173], update_total[244:213], zero pad[247:245]
  output logic [247:0]      m_tdata,
  // m_tuser: status[1:0]
  output logic [1:0]        m_tuser
);

  // configuration
  logic        population_present;
  logic [15:0] spindle_threshold;
  logic [15:0] sw_threshold;
  logic [15:0] variability_threshold;
  logic [23:0] update_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      population_present    <= 1'b0;
      spindle_threshold     <= SPINDLE_THR_RST;
      sw_threshold          <= SLOW_THR_RST;
      variability_threshold <= VAR_THR_RST;
      update_interval       <= INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POP_PRESENT: population_present    <= cfg_data[0];
        REG_SPINDLE_THR: spindle_threshold     <= cfg_data[15:0];
        REG_SLOW_THR:    sw_threshold          <= cfg_data[15:0];
        REG_VAR_THR:     variability_threshold <= cfg_data[15:0];
        REG_INTERVAL:    update_interval       <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // handshake: the update stage moves when the result register is free or being read
  logic in_valid;
  logic out_valid;
  logic advance;
  logic fire;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;
  assign m_tvalid = out_valid;

  // input register: raw fields of the accepted update
  logic [15:0] in_sync;
  logic [23:0] in_rate;
  logic [23:0] in_dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sync <= s_tdata[15:0];
      in_rate <= s_tdata[39:16];
      in_dt   <= s_tdata[63:40];
    end
  end

  // detection on the registered item
  det_t in_det;

  ssc_detect u_detect (
    .synchrony             (in_sync),
    .population_rate       (in_rate),
    .spindle_threshold     (spindle_threshold),
    .sw_threshold          (sw_threshold),
    .variability_threshold (variability_threshold),
    .det                   (in_det)
  );

  // classifier state
  logic [STAGE_W-1:0] current_stage;
  logic               time_started;
  logic [15:0]        rem_act;
  logic [15:0]        rem_decayed;   // always rem_decay(rem_act)
  logic               spindle_flag;
  logic               slow_wave_flag;
  logic [31:0]        spindle_counter;
  logic [31:0]        slow_wave_counter;
  logic [31:0]        run_duration;
  logic [39:0]        per_stage_time [NUM_STAGES];
  logic [15:0]        progress;
  logic [39:0]        elapsed_sum;
  logic [31:0]        update_counter;

  logic [1:0]         status;
  logic               upd;
  logic [STAGE_W-1:0] stage_new;
  logic [STAGE_W-1:0] current_stage_next;
  logic               time_started_next;
  logic [15:0]        rem_act_next;
  logic [15:0]        rem_decayed_next;
  logic               spindle_flag_next;
  logic               slow_wave_flag_next;
  logic [31:0]        spindle_counter_next;
  logic [31:0]        slow_wave_counter_next;
  logic [31:0]        run_duration_next;
  logic [39:0]        pst_rd;
  logic [39:0]        pst_next;
  logic [15:0]        prog_sum;
  logic [15:0]        progress_next;
  logic [39:0]        elapsed_sum_next;
  logic [31:0]        update_counter_next;

  always_comb begin
    // too-soon test comes before the population test
    priority if (time_started && (in_dt < update_interval)) begin
      status = ST_TOO_SOON;
    end else if (!population_present) begin
      status = ST_NO_POP;
    end else begin
      status = ST_UPDATED;
    end
    upd = (status == ST_UPDATED);

    // REM activity: reload on REM, else decay (precomputed at the previous update)
    rem_act_next     = rem_act;
    rem_decayed_next = rem_decayed;
    if (upd) begin
      rem_act_next     = in_det.rem ? ONE_Q15 : rem_decayed;
      rem_decayed_next = in_det.rem ? {1'b0, DECAY_Q15} : rem_decay(rem_decayed);
    end

    priority if (rem_act_next > HALF_Q15) begin
      stage_new = STG_REM;
    end else if (in_det.slow_wave) begin
      stage_new = STG_NREM3;
    end else if (in_det.spindle) begin
      stage_new = STG_NREM2;
    end else if (in_det.low_rate) begin
      stage_new = STG_NREM1;
    end else begin
      stage_new = STG_WAKE;
    end

    current_stage_next     = upd ? stage_new : current_stage;
    spindle_flag_next      = upd ? in_det.spindle : spindle_flag;
    slow_wave_flag_next    = upd ? in_det.slow_wave : slow_wave_flag;
    spindle_counter_next   = (upd && in_det.spindle) ? sat_inc32(spindle_counter)
                                                     : spindle_counter;
    slow_wave_counter_next = (upd && in_det.slow_wave) ? sat_inc32(slow_wave_counter)
                                                       : slow_wave_counter;
    run_duration_next = run_duration;
    if (upd) begin
      run_duration_next = (stage_new == current_stage) ? sat_add32(run_duration, in_dt)
                                                       : 32'd0;
    end

    // single read port on the per-stage times, at the stage shown
    pst_rd   = per_stage_time[current_stage_next];
    pst_next = upd ? sat_add40(pst_rd, in_dt) : pst_rd;

    prog_sum      = progress + STEP_Q15;
    progress_next = progress;
    if (upd && ((stage_new == STG_NREM2) || (stage_new == STG_NREM3))) begin
      progress_next = (prog_sum > ONE_Q15) ? ONE_Q15 : prog_sum;
    end

    update_counter_next = upd ? sat_inc32(update_counter) : update_counter;
    elapsed_sum_next    = upd ? sat_add40(elapsed_sum, in_dt) : elapsed_sum;
    time_started_next   = time_started || (upd && (in_dt != 24'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_stage     <= STG_WAKE;
      time_started      <= 1'b0;
      rem_act           <= 16'd0;
      rem_decayed       <= 16'd0;
      spindle_flag      <= 1'b0;
      slow_wave_flag    <= 1'b0;
      spindle_counter   <= 32'd0;
      slow_wave_counter <= 32'd0;
      run_duration      <= 32'd0;
      progress          <= 16'd0;
      elapsed_sum       <= 40'd0;
      update_counter    <= 32'd0;
      for (int i = 0; i < NUM_STAGES; i++) begin
        per_stage_time[i] <= 40'd0;
      end
    end else if (fire) begin
      current_stage     <= current_stage_next;
      time_started      <= time_started_next;
      rem_act           <= rem_act_next;
      rem_decayed       <= rem_decayed_next;
      spindle_flag      <= spindle_flag_next;
      slow_wave_flag    <= slow_wave_flag_next;
      spindle_counter   <= spindle_counter_next;
      slow_wave_counter <= slow_wave_counter_next;
      run_duration      <= run_duration_next;
      progress          <= progress_next;
      elapsed_sum       <= elapsed_sum_next;
      update_counter    <= update_counter_next;
      per_stage_time[current_stage_next] <= pst_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= status;
      m_tdata <= {3'd0, update_counter_next, elapsed_sum_next, progress_next,
                  pst_next, run_duration_next, slow_wave_counter_next,
                  spindle_counter_next, rem_act_next, slow_wave_flag_next,
                  spindle_flag_next, current_stage_next};
    end
  end

  // checks
  a_progress_cap: assert property (@(posedge clk) disable iff (rst)
    progress <= ONE_Q15)
    else $error("consolidation progress above one");

  a_decay_track: assert property (@(posedge clk) disable iff (rst)
    rem_decayed == rem_decay(rem_act))
    else $error("precomputed REM decay out of step");

  a_started_time: assert property (@(posedge clk) disable iff (rst)
    time_started |-> (elapsed_sum != 40'd0))
    else $error("time started with no accumulated time");

  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && upd && (stage_new != current_stage)) |=> (run_duration == 32'd0))
    else $error("stage run time not cleared on stage change");

  a_skip_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && !upd) |=> $stable(update_counter) && $stable(current_stage))
    else $error("skipped update changed the state");

endmodule

`default_nettype wire

// ===== sv/ssc_detect.sv =====
// ----------------------------------------------------------------------------
// ssc_detect: spindle, slow wave and REM detection
// Compares one item's synchrony and rate against the configured thresholds and fixed rate bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_detect
  import ssc_pkg::*;
(
  input  wire logic [15:0] synchrony,
  input  wire logic [23:0] population_rate,
  input  wire logic [15:0] spindle_threshold,
  input  wire logic [15:0] sw_threshold,
  input  wire logic [15:0] variability_threshold,
  output det_t             det
);

  logic [31:0]        sync_sq;
  logic signed [17:0] var2;
  logic signed [17:0] var_lim;

  always_comb begin
    sync_sq = synchrony * synchrony;
    // 1 - sync, may go negative when synchrony is above one
    var2    = $signed({2'b00, ONE_Q15}) - $signed({2'b00, synchrony});
    var_lim = $signed({1'b0, variability_threshold, 1'b0});

    det.spindle   = sync_sq >= {1'b0, spindle_threshold, 15'd0};
    det.slow_wave = synchrony >= sw_threshold;
    det.rem       = (var2 >= var_lim) && (population_rate >= RATE_LO) &&
                    (population_rate <= RATE_HI);
    det.low_rate  = population_rate < RATE_NREM1;
  end

endmodule

`default_nettype wire
